@@ hdl/ati_pkg.sv @@
// ----------------------------------------------------------------------------
// ati_pkg
// Shared constants, codes and controller/datapath interface types for the
// adaptive trapezoid integrator.
// ----------------------------------------------------------------------------
package ati_pkg;

	localparam int FRAC_BITS    = 24;
	localparam int STACK_DEPTH  = 64;
	localparam int SERIES_TERMS = 40;

	localparam int BOUND_W   = 27;
	localparam int AREA_W    = 56;
	localparam int COUNT_W   = 24;
	localparam int TOL_W     = 25;
	localparam int STATUS_W  = 2;
	localparam int WORD_W    = 64;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 25;
	localparam int ENTRY_W   = 2 * BOUND_W;
	localparam int LEVEL_W   = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W    = $clog2(STACK_DEPTH);
	localparam int K_W       = $clog2(SERIES_TERMS + 1);
	localparam int WHOLE_W   = BOUND_W - FRAC_BITS;

	localparam logic [WORD_W-1:0] ONE_FIX  = WORD_W'(64'd1 << FRAC_BITS);
	localparam logic [WORD_W-1:0] ONE_SQ   = WORD_W'(64'd1 << (2 * FRAC_BITS));
	localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};
	localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

	localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(16777);
	localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(16777215);

	localparam logic [CFG_IDX_W-1:0] REG_TOL   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = CFG_IDX_W'(1);

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] ST_LIMIT    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

	// evaluation points and trapezoids
	localparam logic [1:0] PT_L = 2'd0;
	localparam logic [1:0] PT_M = 2'd1;
	localparam logic [1:0] PT_R = 2'd2;
	localparam logic [1:0] TR_WHOLE = 2'd0;
	localparam logic [1:0] TR_LEFT  = 2'd1;
	localparam logic [1:0] TR_RIGHT = 2'd2;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD_REQ,
		OP_SER_INIT_E1,
		OP_SER_INIT_X,
		OP_MUL_TERM,
		OP_DIV_TERM,
		OP_SUM_ADD,
		OP_E1_STORE,
		OP_EXP_INIT,
		OP_MUL_EXP,
		OP_EXP_UPD,
		OP_DIV_INV,
		OP_C_CALC,
		OP_MUL_C,
		OP_MUL_C2,
		OP_F_STORE,
		OP_MUL_TRAP,
		OP_TRAP_STORE,
		OP_HALVES,
		OP_ACCEPT,
		OP_PUSH_REQ,
		OP_PUSH_L,
		OP_PUSH_R,
		OP_POP,
		OP_LOAD_IV,
		OP_SET_LIMIT,
		OP_RESULT
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHECK_EMPTY,
		S_SER_MUL,
		S_SER_MUL_W,
		S_SER_DIV_W,
		S_SER_END,
		S_PUSH_FIRST,
		S_LOOP,
		S_LOAD_IV,
		S_PT_INIT,
		S_EXP_CHK,
		S_EXP_W,
		S_INV_W,
		S_C_MUL,
		S_C_W,
		S_C2_W,
		S_TRAP,
		S_TRAP_W,
		S_HALVES,
		S_DECIDE,
		S_PUSH_R,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic div_zero;
		logic k_last;
		logic ser_e1;
		logic exp_done;
		logic pt_last;
		logic tr_last;
		logic need_split;
		logic stack_room;
		logic level_zero;
		logic limit_reached;
		logic req_empty;
		logic out_free;
	} sts_t;

endpackage

@@ hdl/ati_mul.sv @@
// ----------------------------------------------------------------------------
// ati_mul
// 64x64 multiply from four 32x32 partial products, shifted right by
// FRAC_BITS or FRAC_BITS+1 and saturated to 64 bits.
// ----------------------------------------------------------------------------
module ati_mul import ati_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] a,
	input  logic [WORD_W-1:0] b,
	input  logic              shift_plus,
	output logic              done,
	output logic [WORD_W-1:0] res
);

	localparam int HALF_W = WORD_W / 2;
	localparam int PROD_W = 2 * WORD_W;

	logic              busy_q;
	logic [2:0]        step_q;
	logic              done_q;
	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] b_q;
	logic              sp_q;
	logic [PROD_W-1:0] acc_q;
	logic [WORD_W-1:0] pp_q;
	logic [1:0]        ppsh_q;
	logic [WORD_W-1:0] res_q;

	logic [HALF_W-1:0] a_part;
	logic [HALF_W-1:0] b_part;
	logic [1:0]        part_sh;
	logic [PROD_W-1:0] pp_ext;
	logic [PROD_W-1:0] shifted;

	always_comb begin
		unique case (step_q)
			3'd0: begin
				a_part  = a_q[HALF_W-1:0];
				b_part  = b_q[HALF_W-1:0];
				part_sh = 2'd0;
			end
			3'd1: begin
				a_part  = a_q[HALF_W-1:0];
				b_part  = b_q[WORD_W-1:HALF_W];
				part_sh = 2'd1;
			end
			3'd2: begin
				a_part  = a_q[WORD_W-1:HALF_W];
				b_part  = b_q[HALF_W-1:0];
				part_sh = 2'd1;
			end
			default: begin
				a_part  = a_q[WORD_W-1:HALF_W];
				b_part  = b_q[WORD_W-1:HALF_W];
				part_sh = 2'd2;
			end
		endcase
	end

	assign pp_ext  = {{WORD_W{1'b0}}, pp_q} << (HALF_W * int'(ppsh_q));
	assign shifted = sp_q ? (acc_q >> (FRAC_BITS + 1)) : (acc_q >> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 3'd0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			sp_q  <= shift_plus;
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q < 3'd4) begin
				pp_q   <= a_part * b_part;
				ppsh_q <= part_sh;
			end
			if (step_q >= 3'd1 && step_q <= 3'd4) begin
				acc_q <= acc_q + pp_ext;
			end
			if (step_q == 3'd5) begin
				res_q <= (|shifted[PROD_W-1:WORD_W]) ? WORD_MAX : shifted[WORD_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

@@ hdl/ati_div.sv @@
// ----------------------------------------------------------------------------
// ati_div
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ati_div import ati_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] num,
	input  logic [WORD_W-1:0] den,
	output logic              done,
	output logic [WORD_W-1:0] quo
);

	localparam int CNT_W = $clog2(WORD_W + 1);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] n_q;
	logic [WORD_W-1:0] d_q;

	logic [WORD_W:0] trial;
	logic            ge;

	assign trial = {rem_q, n_q[WORD_W-1]};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WORD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			n_q   <= num;
			d_q   <= den;
		end else if (busy_q) begin
			rem_q <= ge ? WORD_W'(trial - {1'b0, d_q}) : trial[WORD_W-1:0];
			n_q   <= {n_q[WORD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = n_q;

endmodule

@@ hdl/ati_dp.sv @@
// ----------------------------------------------------------------------------
// ati_dp
// Datapath: configuration registers, interval stack, exp/cosh arithmetic,
// trapezoid sums, area accumulation and the result register.
// ----------------------------------------------------------------------------
module ati_dp import ati_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic [BOUND_W-1:0]   lower_bound,
	input  logic [BOUND_W-1:0]   upper_bound,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [AREA_W-1:0]    area,
	output logic [COUNT_W-1:0]   evaluations,
	output logic [STATUS_W-1:0]  status
);

	function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] x,
			input logic [WORD_W-1:0] y);
		logic [WORD_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[WORD_W] ? WORD_MAX : s[WORD_W-1:0];
	endfunction

	function automatic logic [AREA_W-1:0] clamp_area(input logic [WORD_W-1:0] v);
		return (|v[WORD_W-1:AREA_W]) ? AREA_MAX : v[AREA_W-1:0];
	endfunction

	function automatic logic [AREA_W-1:0] add_area(input logic [AREA_W-1:0] x,
			input logic [AREA_W-1:0] y);
		logic [AREA_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[AREA_W] ? AREA_MAX : s[AREA_W-1:0];
	endfunction

	op_t op;
	assign op = cmd.op;

	logic [TOL_W-1:0]   tol_q;
	logic [COUNT_W-1:0] lim_q;

	logic [BOUND_W-1:0] lo_q, hi_q;
	logic               empty_q;
	logic [BOUND_W-1:0] l_q, m_q, r_q;
	logic [WORD_W-1:0]  term_q, sum_q, e1_q, exp_q, c_q;
	logic [FRAC_BITS:0] f_q;
	logic [K_W-1:0]     k_q;
	logic               e1mode_q;
	logic [WHOLE_W-1:0] cnt_q;
	logic [AREA_W-1:0]  fl_q, fm_q, fr_q;
	logic [AREA_W-1:0]  tw_q, tl_q, tr_area_q, halves_q;
	logic [1:0]         pt_q, tr_q;
	logic [AREA_W-1:0]  area_q;
	logic [COUNT_W-1:0] count_q;
	logic [LEVEL_W-1:0] level_q;
	logic               ovf_q, limit_q;
	logic [ENTRY_W-1:0] rd_q;
	logic [ENTRY_W-1:0] stack_mem [STACK_DEPTH];

	logic                out_valid_q;
	logic [AREA_W-1:0]   out_area_q;
	logic [COUNT_W-1:0]  out_eval_q;
	logic [STATUS_W-1:0] out_status_q;

	// arithmetic units
	logic              mul_start, mul_sp, mul_done;
	logic [WORD_W-1:0] mul_a, mul_b, mul_res;
	logic              div_start, div_done;
	logic [WORD_W-1:0] div_n, div_d, div_res;

	ati_mul u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (mul_start),
		.a          (mul_a),
		.b          (mul_b),
		.shift_plus (mul_sp),
		.done       (mul_done),
		.res        (mul_res)
	);

	ati_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_n),
		.den    (div_d),
		.done   (div_done),
		.quo    (div_res)
	);

	logic [AREA_W:0]    trap_sum;
	logic [BOUND_W-1:0] trap_width;

	always_comb begin
		unique case (tr_q)
			TR_WHOLE: begin
				trap_sum   = {1'b0, fl_q} + {1'b0, fr_q};
				trap_width = r_q - l_q;
			end
			TR_LEFT: begin
				trap_sum   = {1'b0, fl_q} + {1'b0, fm_q};
				trap_width = m_q - l_q;
			end
			default: begin
				trap_sum   = {1'b0, fm_q} + {1'b0, fr_q};
				trap_width = r_q - m_q;
			end
		endcase
	end

	always_comb begin
		mul_start = 1'b0;
		mul_sp    = 1'b0;
		mul_a     = term_q;
		mul_b     = WORD_W'(f_q);
		div_start = 1'b0;
		div_n     = mul_res;
		div_d     = WORD_W'(k_q);
		unique case (op)
			OP_MUL_TERM: mul_start = 1'b1;
			OP_MUL_EXP: begin
				mul_start = 1'b1;
				mul_a     = exp_q;
				mul_b     = e1_q;
			end
			OP_MUL_C: begin
				mul_start = 1'b1;
				mul_a     = c_q;
				mul_b     = c_q;
			end
			OP_MUL_C2: begin
				mul_start = 1'b1;
				mul_a     = mul_res;
				mul_b     = mul_res;
			end
			OP_MUL_TRAP: begin
				mul_start = 1'b1;
				mul_sp    = 1'b1;
				mul_a     = WORD_W'(trap_sum);
				mul_b     = WORD_W'(trap_width);
			end
			OP_DIV_TERM: div_start = 1'b1;
			OP_DIV_INV: begin
				div_start = 1'b1;
				div_n     = ONE_SQ;
				div_d     = exp_q;
			end
			default: ;
		endcase
	end

	logic [BOUND_W-1:0] x_sel;
	always_comb begin
		unique case (pt_q)
			PT_L:    x_sel = l_q;
			PT_M:    x_sel = m_q;
			default: x_sel = r_q;
		endcase
	end

	logic [AREA_W-1:0] diff;
	assign diff = (halves_q >= tw_q) ? (halves_q - tw_q) : (tw_q - halves_q);
	logic need_split;
	assign need_split = {1'b0, diff} > (AREA_W + 1)'(tol_q);

	logic [BOUND_W:0]   mid_sum;
	logic [ADDR_W-1:0]  wr_addr, rd_addr;
	logic [LEVEL_W-1:0] level_dec;
	assign mid_sum   = {1'b0, rd_q[BOUND_W-1:0]} + {1'b0, rd_q[ENTRY_W-1:BOUND_W]};
	assign level_dec = level_q - LEVEL_W'(1);
	assign wr_addr   = level_q[ADDR_W-1:0];
	assign rd_addr   = level_dec[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q       <= TOL_RESET;
			lim_q       <= LIMIT_RESET;
			empty_q     <= 1'b0;
			level_q     <= '0;
			count_q     <= '0;
			area_q      <= '0;
			ovf_q       <= 1'b0;
			limit_q     <= 1'b0;
			e1mode_q    <= 1'b0;
			k_q         <= '0;
			cnt_q       <= '0;
			pt_q        <= PT_L;
			tr_q        <= TR_WHOLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_TOL) begin
					tol_q <= cfg_data;
				end else if (cfg_index == REG_LIMIT) begin
					lim_q <= cfg_data[COUNT_W-1:0];
				end
			end
			if (op == OP_RESULT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (op)
				OP_LOAD_REQ: begin
					empty_q <= upper_bound <= lower_bound;
					level_q <= '0;
					count_q <= '0;
					area_q  <= '0;
					ovf_q   <= 1'b0;
					limit_q <= 1'b0;
				end
				OP_SER_INIT_E1: begin
					e1mode_q <= 1'b1;
					k_q      <= K_W'(1);
				end
				OP_SER_INIT_X: begin
					e1mode_q <= 1'b0;
					k_q      <= K_W'(1);
					cnt_q    <= x_sel[BOUND_W-1:FRAC_BITS];
				end
				OP_SUM_ADD: k_q <= k_q + K_W'(1);
				OP_EXP_UPD: cnt_q <= cnt_q - WHOLE_W'(1);
				OP_F_STORE: pt_q <= pt_q + 2'd1;
				OP_TRAP_STORE: tr_q <= tr_q + 2'd1;
				OP_ACCEPT: begin
					area_q <= add_area(area_q, halves_q);
					ovf_q  <= ovf_q | need_split;
				end
				OP_PUSH_REQ, OP_PUSH_L, OP_PUSH_R: level_q <= level_q + LEVEL_W'(1);
				OP_POP: begin
					level_q <= level_dec;
					count_q <= count_q + COUNT_W'(1);
				end
				OP_LOAD_IV: begin
					pt_q <= PT_L;
					tr_q <= TR_WHOLE;
				end
				OP_SET_LIMIT: limit_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD_REQ: begin
				lo_q <= lower_bound;
				hi_q <= upper_bound;
			end
			OP_SER_INIT_E1: begin
				term_q <= ONE_FIX;
				sum_q  <= ONE_FIX;
				f_q    <= ONE_FIX[FRAC_BITS:0];
			end
			OP_SER_INIT_X: begin
				term_q <= ONE_FIX;
				sum_q  <= ONE_FIX;
				f_q    <= {1'b0, x_sel[FRAC_BITS-1:0]};
			end
			OP_SUM_ADD: begin
				term_q <= div_res;
				sum_q  <= sat_add(sum_q, div_res);
			end
			OP_E1_STORE: e1_q <= sum_q;
			OP_EXP_INIT: exp_q <= sum_q;
			OP_EXP_UPD: exp_q <= mul_res;
			OP_C_CALC: c_q <= sat_add(exp_q, div_res) >> 1;
			OP_F_STORE: begin
				unique case (pt_q)
					PT_L:    fl_q <= clamp_area(mul_res);
					PT_M:    fm_q <= clamp_area(mul_res);
					default: fr_q <= clamp_area(mul_res);
				endcase
			end
			OP_TRAP_STORE: begin
				unique case (tr_q)
					TR_WHOLE: tw_q      <= clamp_area(mul_res);
					TR_LEFT:  tl_q      <= clamp_area(mul_res);
					default:  tr_area_q <= clamp_area(mul_res);
				endcase
			end
			OP_HALVES: halves_q <= add_area(tl_q, tr_area_q);
			OP_LOAD_IV: begin
				l_q <= rd_q[BOUND_W-1:0];
				r_q <= rd_q[ENTRY_W-1:BOUND_W];
				m_q <= mid_sum[BOUND_W:1];
			end
			OP_RESULT: begin
				out_area_q <= area_q;
				out_eval_q <= count_q;
				priority if (empty_q) begin
					out_status_q <= ST_EMPTY;
				end else if (limit_q) begin
					out_status_q <= ST_LIMIT;
				end else if (ovf_q) begin
					out_status_q <= ST_OVERFLOW;
				end else begin
					out_status_q <= ST_OK;
				end
			end
			default: ;
		endcase
	end

	// interval stack
	always_ff @(posedge clk) begin
		unique case (op)
			OP_PUSH_REQ: stack_mem[wr_addr] <= {hi_q, lo_q};
			OP_PUSH_L:   stack_mem[wr_addr] <= {m_q, l_q};
			OP_PUSH_R:   stack_mem[wr_addr] <= {r_q, m_q};
			default: ;
		endcase
		if (op == OP_POP) begin
			rd_q <= stack_mem[rd_addr];
		end
	end

	always_comb begin
		sts.mul_done      = mul_done;
		sts.div_done      = div_done;
		sts.div_zero      = div_res == '0;
		sts.k_last        = k_q == K_W'(SERIES_TERMS);
		sts.ser_e1        = e1mode_q;
		sts.exp_done      = (cnt_q == '0) || (exp_q == WORD_MAX);
		sts.pt_last       = pt_q == PT_R;
		sts.tr_last       = tr_q == TR_RIGHT;
		sts.need_split    = need_split;
		sts.stack_room    = level_q <= LEVEL_W'(STACK_DEPTH - 2);
		sts.level_zero    = level_q == '0;
		sts.limit_reached = count_q >= lim_q;
		sts.req_empty     = empty_q;
		sts.out_free      = !out_valid_q || !out_stall;
	end

	assign out_valid   = out_valid_q;
	assign area        = out_area_q;
	assign evaluations = out_eval_q;
	assign status      = out_status_q;

endmodule

@@ hdl/ati_ctrl.sv @@
// ----------------------------------------------------------------------------
// ati_ctrl
// Sequencer: walks the interval stack; unless waiting on mul/div/output, it
// issues one datapath command a cycle: exp series, cosh^4, trapezoids, split.
// ----------------------------------------------------------------------------
module ati_ctrl import ati_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD_REQ;
					state_d = S_CHECK_EMPTY;
				end
			end
			S_CHECK_EMPTY: begin
				if (sts.req_empty) begin
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_SER_INIT_E1;
					state_d = S_SER_MUL;
				end
			end
			S_SER_MUL: begin
				cmd.op  = OP_MUL_TERM;
				state_d = S_SER_MUL_W;
			end
			S_SER_MUL_W: begin
				if (sts.mul_done) begin
					cmd.op  = OP_DIV_TERM;
					state_d = S_SER_DIV_W;
				end
			end
			S_SER_DIV_W: begin
				if (sts.div_done) begin
					if (sts.div_zero) begin
						state_d = S_SER_END;
					end else begin
						cmd.op  = OP_SUM_ADD;
						state_d = sts.k_last ? S_SER_END : S_SER_MUL;
					end
				end
			end
			S_SER_END: begin
				if (sts.ser_e1) begin
					cmd.op  = OP_E1_STORE;
					state_d = S_PUSH_FIRST;
				end else begin
					cmd.op  = OP_EXP_INIT;
					state_d = S_EXP_CHK;
				end
			end
			S_PUSH_FIRST: begin
				cmd.op  = OP_PUSH_REQ;
				state_d = S_LOOP;
			end
			S_LOOP: begin
				priority if (sts.level_zero) begin
					state_d = S_DONE;
				end else if (sts.limit_reached) begin
					cmd.op  = OP_SET_LIMIT;
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_POP;
					state_d = S_LOAD_IV;
				end
			end
			S_LOAD_IV: begin
				cmd.op  = OP_LOAD_IV;
				state_d = S_PT_INIT;
			end
			S_PT_INIT: begin
				cmd.op  = OP_SER_INIT_X;
				state_d = S_SER_MUL;
			end
			S_EXP_CHK: begin
				if (sts.exp_done) begin
					cmd.op  = OP_DIV_INV;
					state_d = S_INV_W;
				end else begin
					cmd.op  = OP_MUL_EXP;
					state_d = S_EXP_W;
				end
			end
			S_EXP_W: begin
				if (sts.mul_done) begin
					cmd.op  = OP_EXP_UPD;
					state_d = S_EXP_CHK;
				end
			end
			S_INV_W: begin
				if (sts.div_done) begin
					cmd.op  = OP_C_CALC;
					state_d = S_C_MUL;
				end
			end
			S_C_MUL: begin
				cmd.op  = OP_MUL_C;
				state_d = S_C_W;
			end
			S_C_W: begin
				if (sts.mul_done) begin
					cmd.op  = OP_MUL_C2;
					state_d = S_C2_W;
				end
			end
			S_C2_W: begin
				if (sts.mul_done) begin
					cmd.op  = OP_F_STORE;
					state_d = sts.pt_last ? S_TRAP : S_PT_INIT;
				end
			end
			S_TRAP: begin
				cmd.op  = OP_MUL_TRAP;
				state_d = S_TRAP_W;
			end
			S_TRAP_W: begin
				if (sts.mul_done) begin
					cmd.op  = OP_TRAP_STORE;
					state_d = sts.tr_last ? S_HALVES : S_TRAP;
				end
			end
			S_HALVES: begin
				cmd.op  = OP_HALVES;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.need_split && sts.stack_room) begin
					cmd.op  = OP_PUSH_L;
					state_d = S_PUSH_R;
				end else begin
					cmd.op  = OP_ACCEPT;
					state_d = S_LOOP;
				end
			end
			S_PUSH_R: begin
				cmd.op  = OP_PUSH_R;
				state_d = S_LOOP;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.op  = OP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall = state_q != S_IDLE;

endmodule

@@ hdl/adaptive_trapezoid_integrator_unit.sv @@
// ----------------------------------------------------------------------------
// adaptive_trapezoid_integrator_unit
// Adaptive trapezoid integration of cosh(x)^4 over one interval per item.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes lower_bound and upper_bound, Q.24.
// Output channel (out_valid/out_stall) gives area, evaluations and status,
// one result per input item. The config channel (cfg_valid/cfg_ready, always
// ready) writes error_tolerance (index 0) and evaluation_limit (index 1);
// other indexes are ignored. Write config only while the block is idle.
// One item is worked on at a time; in_stall is high from acceptance until
// the result is loaded into the output register. An empty interval goes from
// S_CHECK_EMPTY straight to S_DONE. Otherwise the block sums the exp(1)
// series once per item, then three exp series per evaluated interval, and
// each term of a series goes through the multiplier and the bit-serial
// divider.
// Reset clears the sequencer, the counters and the output valid, and loads
// the register defaults. A stalled result stays in the output register; the
// next item may be accepted meanwhile, and its result waits until the
// register is free.
// ----------------------------------------------------------------------------
module adaptive_trapezoid_integrator_unit import ati_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BOUND_W-1:0]   lower_bound,
	input  logic [BOUND_W-1:0]   upper_bound,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [AREA_W-1:0]    area,
	output logic [COUNT_W-1:0]   evaluations,
	output logic [STATUS_W-1:0]  status,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	ati_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	ati_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.lower_bound (lower_bound),
		.upper_bound (upper_bound),
		.cfg_valid   (cfg_valid & cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.area        (area),
		.evaluations (evaluations),
		.status      (status)
	);

endmodule
